// ===== rtl/ivtb_pkg.sv =====
package ivtb_pkg;

    localparam int VertexCount  = 4096;
    localparam int AddrW        = $clog2(VertexCount);
    localparam int FractionBits = 16;

    localparam logic [2:0] CfgRow0A  = 3'd0;
    localparam logic [2:0] CfgRow0B  = 3'd1;
    localparam logic [2:0] CfgRow1A  = 3'd2;
    localparam logic [2:0] CfgRow1B  = 3'd3;
    localparam logic [2:0] CfgRow2A  = 3'd4;
    localparam logic [2:0] CfgRow2B  = 3'd5;
    localparam logic [2:0] CfgXfEn   = 3'd6;
    localparam logic [2:0] CfgIdxTyp = 3'd7;

    localparam logic [1:0] IdxByte    = 2'd0;
    localparam logic [1:0] IdxHalf    = 2'd1;
    localparam logic [1:0] IdxWord    = 2'd2;
    localparam logic [1:0] IdxInvalid = 2'd3;

    localparam logic [1:0] ErrNone  = 2'd0;
    localparam logic [1:0] ErrType  = 2'd1;
    localparam logic [1:0] ErrRange = 2'd2;

    localparam logic signed [31:0] SMax = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SMin = 32'sh8000_0000;

    localparam logic CmdWrite = 1'b0;

    typedef struct packed {
        logic [31:0] index;
        logic        hit;
        logic        last;
        logic [1:0]  err;
    } t_tag;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'(SMax)) r = SMax;
        else if (v < 64'(SMin)) r = SMin;
        else r = v[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/ivtb_store.sv =====
module ivtb_store (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ivtb_pkg::AddrW-1:0]   i_waddr,
    input  ivtb_pkg::t_vec               i_wdata,
    input  logic                         i_re,
    input  logic [ivtb_pkg::AddrW-1:0]   i_raddr,
    output ivtb_pkg::t_vec               o_rdata
);
    ivtb_pkg::t_vec r_mem [ivtb_pkg::VertexCount];
    ivtb_pkg::t_vec r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rd;
endmodule

// ===== rtl/ivtb_xform.sv =====
module ivtb_xform (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [63:0]         i_wa,
    input  logic [63:0]         i_wb,
    input  ivtb_pkg::t_vec      i_v,
    output logic signed [31:0]  o_res
);
    logic signed [63:0] n_p0, n_p1, n_p2;
    logic signed [63:0] r_p0, r_p1, r_p2;
    logic signed [31:0] r_t;
    logic signed [63:0] n_sum;

    assign n_p0 = $signed(i_wa[31:0])  * i_v.x;
    assign n_p1 = $signed(i_wa[63:32]) * i_v.y;
    assign n_p2 = $signed(i_wb[31:0])  * i_v.z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_t  <= $signed(i_wb[63:32]);
        end
    end

    assign n_sum = (r_p0 >>> ivtb_pkg::FractionBits)
                 + (r_p1 >>> ivtb_pkg::FractionBits)
                 + (r_p2 >>> ivtb_pkg::FractionBits)
                 + 64'(r_t);
    assign o_res = ivtb_pkg::sat32(n_sum);
endmodule

// ===== rtl/indexed_vertex_transform_bbox_core.sv =====
// Channel | valid     | stall     | payload
// input   | i_valid   | o_stall   | i_command, i_vertex_index, i_pos_*, i_final_index
// output  | o_valid   | i_stall   | o_out_index .. o_error
// One item per cycle while the output is not stalled. Pipeline: store read, multiply, sum/box plus output register.
// Writes make no result.
// Reset clears valids, corner count, box and configuration registers. No clearing pass.
// Output stall freezes the whole pipeline; input stall follows it.
module indexed_vertex_transform_bbox_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_command,
    input  logic [31:0]         i_vertex_index,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic                i_final_index,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [31:0]         o_out_index,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_z,
    output logic                o_triangle_done,
    output logic                o_list_done,
    output logic signed [31:0]  o_min_x,
    output logic signed [31:0]  o_min_y,
    output logic signed [31:0]  o_min_z,
    output logic signed [31:0]  o_max_x,
    output logic signed [31:0]  o_max_y,
    output logic [1:0]          o_error
);
    logic [63:0] r_row0_a, r_row0_b, r_row1_a, r_row1_b, r_row2_a, r_row2_b;
    logic        r_xf_en;
    logic [1:0]  r_idx_type;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0_a   <= 64'h0000_0000_0001_0000;
            r_row0_b   <= '0;
            r_row1_a   <= 64'h0001_0000_0000_0000;
            r_row1_b   <= '0;
            r_row2_a   <= '0;
            r_row2_b   <= 64'h0001_0000_0000_0000;
            r_xf_en    <= 1'b0;
            r_idx_type <= ivtb_pkg::IdxWord;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ivtb_pkg::CfgRow0A:  r_row0_a <= i_cfg_data;
                ivtb_pkg::CfgRow0B:  r_row0_b <= i_cfg_data;
                ivtb_pkg::CfgRow1A:  r_row1_a <= i_cfg_data;
                ivtb_pkg::CfgRow1B:  r_row1_b <= i_cfg_data;
                ivtb_pkg::CfgRow2A:  r_row2_a <= i_cfg_data;
                ivtb_pkg::CfgRow2B:  r_row2_b <= i_cfg_data;
                ivtb_pkg::CfgXfEn:   r_xf_en <= i_cfg_data[0];
                ivtb_pkg::CfgIdxTyp: r_idx_type <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    logic in_xfer;
    assign in_xfer = i_valid && adv;

    // stage 0 decode
    logic [31:0] n_midx;
    logic [1:0]  n_err;
    always_comb begin
        case (r_idx_type)
            ivtb_pkg::IdxByte: n_midx = {24'd0, i_vertex_index[7:0]};
            ivtb_pkg::IdxHalf: n_midx = {16'd0, i_vertex_index[15:0]};
            default:           n_midx = i_vertex_index;
        endcase
        if (r_idx_type == ivtb_pkg::IdxInvalid) begin
            n_err  = ivtb_pkg::ErrType;
            n_midx = '0;
        end else if (n_midx >= 32'(ivtb_pkg::VertexCount)) begin
            n_err = ivtb_pkg::ErrRange;
        end else begin
            n_err = ivtb_pkg::ErrNone;
        end
    end

    logic we;
    assign we = in_xfer && (i_command == ivtb_pkg::CmdWrite)
             && (i_vertex_index < 32'(ivtb_pkg::VertexCount));

    ivtb_pkg::t_vec rd, wvec;
    assign wvec = '{x: i_pos_x, y: i_pos_y, z: i_pos_z};

    // A write lands before any later read reaches the read port.
    ivtb_store u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(i_vertex_index[ivtb_pkg::AddrW-1:0]),
        .i_wdata(wvec),
        .i_re   (adv),
        .i_raddr(n_midx[ivtb_pkg::AddrW-1:0]),
        .o_rdata(rd)
    );

    logic           r_v1, r_v2, r_v3;
    ivtb_pkg::t_tag r_t1, r_t2;
    ivtb_pkg::t_vec r_raw2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= in_xfer && (i_command != ivtb_pkg::CmdWrite);
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t1   <= '{index: n_midx, hit: (n_err == ivtb_pkg::ErrNone),
                        last: i_final_index, err: n_err};
            r_t2   <= r_t1;
            r_raw2 <= rd;
        end
    end

    logic signed [31:0] tx, ty, tz;
    ivtb_xform u_x (.i_clk(i_clk), .i_en(adv), .i_wa(r_row0_a), .i_wb(r_row0_b),
                    .i_v(rd), .o_res(tx));
    ivtb_xform u_y (.i_clk(i_clk), .i_en(adv), .i_wa(r_row1_a), .i_wb(r_row1_b),
                    .i_v(rd), .o_res(ty));
    ivtb_xform u_z (.i_clk(i_clk), .i_en(adv), .i_wa(r_row2_a), .i_wb(r_row2_b),
                    .i_v(rd), .o_res(tz));

    ivtb_pkg::t_vec v;
    assign v = r_xf_en ? {tx, ty, tz} : r_raw2;

    logic signed [31:0] r_bmin_x, r_bmin_y, r_bmin_z, r_bmax_x, r_bmax_y, r_bmax_z;
    logic [1:0]         r_corner;
    logic signed [31:0] n_bmin_x, n_bmin_y, n_bmin_z, n_bmax_x, n_bmax_y, n_bmax_z;
    logic [1:0]         n_corner;
    logic               n_tri, hit;

    assign hit = r_v2 && r_t2.hit;

    always_comb begin
        n_bmin_x = r_bmin_x; n_bmin_y = r_bmin_y; n_bmin_z = r_bmin_z;
        n_bmax_x = r_bmax_x; n_bmax_y = r_bmax_y; n_bmax_z = r_bmax_z;
        n_corner = r_corner;
        n_tri    = 1'b0;
        if (hit) begin
            if (v.x < r_bmin_x) n_bmin_x = v.x;
            if (v.y < r_bmin_y) n_bmin_y = v.y;
            if (v.z < r_bmin_z) n_bmin_z = v.z;
            if (v.x > r_bmax_x) n_bmax_x = v.x;
            if (v.y > r_bmax_y) n_bmax_y = v.y;
            if (v.z > r_bmax_z) n_bmax_z = v.z;
            n_corner = r_corner + 2'd1;
            if (n_corner == 2'd3 || r_t2.last) begin
                n_tri    = 1'b1;
                n_corner = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3     <= 1'b0;
            r_corner <= '0;
            r_bmin_x <= ivtb_pkg::SMax; r_bmin_y <= ivtb_pkg::SMax;
            r_bmin_z <= ivtb_pkg::SMax;
            r_bmax_x <= ivtb_pkg::SMin; r_bmax_y <= ivtb_pkg::SMin;
            r_bmax_z <= ivtb_pkg::SMin;
        end else if (adv) begin
            r_v3     <= r_v2;
            r_corner <= n_corner;
            r_bmin_x <= n_bmin_x; r_bmin_y <= n_bmin_y; r_bmin_z <= n_bmin_z;
            r_bmax_x <= n_bmax_x; r_bmax_y <= n_bmax_y; r_bmax_z <= n_bmax_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_out_index     <= r_t2.index;
            o_out_x         <= r_t2.hit ? v.x : 32'sd0;
            o_out_y         <= r_t2.hit ? v.y : 32'sd0;
            o_out_z         <= r_t2.hit ? v.z : 32'sd0;
            o_triangle_done <= n_tri;
            o_list_done     <= r_t2.hit && r_t2.last;
            o_error         <= r_t2.err;
        end
    end

    assign o_valid = r_v3;
    assign o_min_x = r_bmin_x;
    assign o_min_y = r_bmin_y;
    assign o_min_z = r_bmin_z;
    assign o_max_x = r_bmax_x;
    assign o_max_y = r_bmax_y;
endmodule

// ===== rtl/ivtb_checker.sv =====
module ivtb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_stall,
    input logic       o_triangle_done,
    input logic       o_list_done,
    input logic [1:0] o_error
);
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_error != ivtb_pkg::IdxInvalid) else $error("bad error code");
    a_list_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_list_done) |-> o_triangle_done) else $error("list end without triangle");
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error != ivtb_pkg::ErrNone) |-> !o_triangle_done && !o_list_done)
        else $error("error result carries flags");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall)) else $error("input stalled without cause");
endmodule

bind indexed_vertex_transform_bbox_core ivtb_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_stall(o_stall), .o_triangle_done(o_triangle_done),
    .o_list_done(o_list_done), .o_error(o_error)
);
